// ===== hdl/rhe_pkg.sv =====
`timescale 1ns / 1ps

package rhe_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int unsigned COORD_W = 31;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned POINT_W = 2 * COORD_W;

  // Step distance coefficients: 0.011 and 0.01863 in Q0.32
  localparam logic [26:0] STEP_COEF_X = 27'd47244640;
  localparam logic [26:0] STEP_COEF_Y = 27'd80015241;
  localparam int unsigned COEF_W      = 27;
  localparam int unsigned PROD_W      = COORD_W + COEF_W;
  localparam int unsigned TERM_W      = PROD_W + 1 - 16;
  localparam int unsigned TOTAL_W     = TERM_W + 1;

  // Vector datapath: magnitude normalized to 2^40, CORDIC gain stays below 2^43
  localparam int unsigned VEC_W       = 46;
  localparam int unsigned ATAN_ENTRIES = 24;

  typedef struct packed {
    logic [1:0]          operation;
    logic [INDEX_W-1:0]  point_index;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic                walk_forward;
    logic [15:0]         bearing_angle;
    logic                bearing_given;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [15:0] route_angle;
    logic               same_direction;
  } out_item_t;

  // Arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/rhe_ram.sv =====
`timescale 1ns / 1ps

module rhe_ram #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/route_heading_estimator_unit.sv =====
`timescale 1ns / 1ps

// Channel   Ports                       Transfer
// --------  --------------------------  ------------------------------------
// input     start, busy, in_item        edge with start high and busy low
// result    out_strobe, out_result      edge ending the one-cycle strobe
// config    cfg_wr_en, cfg_wr_data      edge with cfg_wr_en high
//
// Write, count and bad requests answer straight from S_DECODE. An accepted
// query walks the store, with one store read and two passes through the shared
// multiplier per step, then normalizes and runs the CORDIC loop, or goes
// straight to S_FIN for a zero vector.
// busy stays high until the result strobe. Reset is synchronous, active low,
// needs no clearing pass, and the receiver cannot stall the result.

module route_heading_estimator_unit
  import rhe_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_result,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_START, S_NEXT, S_POINT, S_MULX, S_MULY,
    S_TERM, S_ADD, S_VEC, S_NORM, S_ROT, S_FIN
  } state_t;

  state_t                   state_r, state_nxt;
  in_item_t                 req_r, req_nxt;
  logic [INDEX_W-1:0]       count_r, count_nxt;
  logic [31:0]              thresh_r, thresh_nxt;
  logic [INDEX_W-1:0]       cur_r, cur_nxt;
  logic                     stepped_r, stepped_nxt;
  logic [COORD_W-1:0]       sx_r, sx_nxt, sy_r, sy_nxt;
  logic [COORD_W-1:0]       px_r, px_nxt, py_r, py_nxt;
  logic [COORD_W-1:0]       dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt, psum_r, psum_nxt;
  logic [TERM_W-1:0]        term_r, term_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  logic signed [VEC_W-1:0]  re_r, re_nxt, im_r, im_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [SW-1:0]            rot_i_r, rot_i_nxt;
  logic                     out_strobe_r, out_strobe_nxt;
  out_item_t                out_r, out_nxt;

  // Point store signals
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [POINT_W-1:0]       ram_wdata, ram_rdata;
  logic [COORD_W-1:0]       rd_x, rd_y;

  // Shared multiplier
  logic [COORD_W-1:0]       mul_a;
  logic [COEF_W-1:0]        mul_b;
  logic [PROD_W-1:0]        mul_p;

  // Misc datapath values
  logic [PROD_W:0]          step_sum;
  logic signed [VEC_W-1:0]  re_v, im_v, im_abs, mag, re_sh, im_sh;
  logic [31:0]              atan_v, rounded;
  logic [15:0]              ang_v, diff_v;
  logic                     idx_in_store, idx_count_ok;

  rhe_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_x = ram_rdata[POINT_W-1:COORD_W];
  assign rd_y = ram_rdata[COORD_W-1:0];

  assign ram_waddr = AW'(req_r.point_index);
  assign ram_wdata = {req_r.coord_x, req_r.coord_y};

  assign mul_a = (state_r == S_MULX) ? dx_r : dy_r;
  assign mul_b = (state_r == S_MULX) ? STEP_COEF_X : STEP_COEF_Y;
  assign mul_p = mul_a * mul_b;

  assign idx_in_store = 32'(req_r.point_index) < 32'(MAX_POINTS);
  assign idx_count_ok = 32'(req_r.point_index) <= 32'(MAX_POINTS);

  // Rounded step term and vector setup
  assign step_sum = (PROD_W + 1)'(psum_r) + (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(16'h8000);
  assign re_v     = VEC_W'(sy_r) - VEC_W'(py_r);
  assign im_v     = VEC_W'(sx_r) - VEC_W'(px_r);

  // Normalize and CORDIC helpers
  assign im_abs = im_r[VEC_W-1] ? -im_r : im_r;
  assign mag    = (re_r > im_abs) ? re_r : im_abs;
  assign re_sh  = re_r >>> rot_i_r;
  assign im_sh  = im_r >>> rot_i_r;
  assign atan_v = atan_entry(5'(rot_i_r));

  // Final angle and bearing check
  assign rounded = acc_r + 32'h0000_8000;
  assign ang_v   = 16'd0 - rounded[31:16];
  assign diff_v  = ang_v - req_r.bearing_angle;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    count_nxt      = count_r;
    thresh_nxt     = thresh_r;
    cur_nxt        = cur_r;
    stepped_nxt    = stepped_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    prod_nxt       = prod_r;
    psum_nxt       = psum_r;
    term_nxt       = term_r;
    total_nxt      = total_r;
    re_nxt         = re_r;
    im_nxt         = im_r;
    acc_nxt        = acc_r;
    rot_i_nxt      = rot_i_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_raddr      = AW'(cur_r);

    if (cfg_wr_en) begin
      thresh_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        out_nxt   = '0;
        state_nxt = S_IDLE;
        case (req_r.operation)
          OP_WRITE: begin
            if (idx_in_store) begin
              ram_we = 1'b1;
            end else begin
              out_nxt.status = 1'b1;
            end
            out_strobe_nxt = 1'b1;
          end
          OP_COUNT: begin
            if (idx_count_ok) begin
              count_nxt = req_r.point_index;
            end else begin
              out_nxt.status = 1'b1;
            end
            out_strobe_nxt = 1'b1;
          end
          OP_QUERY: begin
            if (req_r.point_index >= count_r || !idx_in_store) begin
              out_nxt.status = 1'b1;
              out_strobe_nxt = 1'b1;
            end else begin
              ram_raddr   = AW'(req_r.point_index);
              cur_nxt     = req_r.point_index;
              stepped_nxt = 1'b0;
              total_nxt   = '0;
              state_nxt   = S_START;
            end
          end
          default: begin
            out_nxt.status = 1'b1;
            out_strobe_nxt = 1'b1;
          end
        endcase
      end

      // Start point arrives from the store
      S_START: begin
        sx_nxt    = rd_x;
        sy_nxt    = rd_y;
        px_nxt    = rd_x;
        py_nxt    = rd_y;
        state_nxt = S_NEXT;
      end

      // Stop test and next point fetch
      S_NEXT: begin
        if (stepped_r && total_r >= TOTAL_W'(thresh_r)) begin
          state_nxt = S_VEC;
        end else if (req_r.walk_forward) begin
          if ({1'b0, cur_r} + 1'b1 >= {1'b0, count_r}) begin
            state_nxt = S_VEC;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            ram_raddr = AW'(cur_nxt);
            state_nxt = S_POINT;
          end
        end else begin
          if (cur_r == '0) begin
            state_nxt = S_VEC;
          end else begin
            cur_nxt   = cur_r - 1'b1;
            ram_raddr = AW'(cur_nxt);
            state_nxt = S_POINT;
          end
        end
      end

      S_POINT: begin
        px_nxt      = rd_x;
        py_nxt      = rd_y;
        dx_nxt      = (rd_x > sx_r) ? rd_x - sx_r : sx_r - rd_x;
        dy_nxt      = (rd_y > sy_r) ? rd_y - sy_r : sy_r - rd_y;
        stepped_nxt = 1'b1;
        state_nxt   = S_MULX;
      end

      S_MULX: begin
        prod_nxt  = mul_p;
        state_nxt = S_MULY;
      end

      S_MULY: begin
        psum_nxt  = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_TERM;
      end

      S_TERM: begin
        term_nxt  = step_sum[PROD_W:16];
        state_nxt = S_ADD;
      end

      S_ADD: begin
        total_nxt = total_r + TOTAL_W'(term_r);
        state_nxt = S_NEXT;
      end

      // Heading vector, half-turn pre-rotation for the left half plane
      S_VEC: begin
        rot_i_nxt = '0;
        if (re_v == '0 && im_v == '0) begin
          acc_nxt   = '0;
          state_nxt = S_FIN;
        end else if (re_v < 0) begin
          re_nxt    = -re_v;
          im_nxt    = -im_v;
          acc_nxt   = 32'h8000_0000;
          state_nxt = S_NORM;
        end else begin
          re_nxt    = re_v;
          im_nxt    = im_v;
          acc_nxt   = '0;
          state_nxt = S_NORM;
        end
      end

      // Bring the larger magnitude up to 2^40: byte steps, then bit steps
      S_NORM: begin
        if (mag[VEC_W-1:32] == '0) begin
          re_nxt = re_r <<< 8;
          im_nxt = im_r <<< 8;
        end else if (mag[VEC_W-1:40] == '0) begin
          re_nxt = re_r <<< 1;
          im_nxt = im_r <<< 1;
        end else begin
          state_nxt = S_ROT;
        end
      end

      // One vectoring iteration per cycle
      S_ROT: begin
        if (!im_r[VEC_W-1]) begin
          re_nxt  = re_r + im_sh;
          im_nxt  = im_r - re_sh;
          acc_nxt = acc_r + atan_v;
        end else begin
          re_nxt  = re_r - im_sh;
          im_nxt  = im_r + re_sh;
          acc_nxt = acc_r - atan_v;
        end
        rot_i_nxt = rot_i_r + 1'b1;
        if (rot_i_r == SW'(CORDIC_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        out_nxt.status      = 1'b0;
        out_nxt.route_angle = ang_v;
        if (req_r.bearing_given) begin
          out_nxt.same_direction = (diff_v < 16'd16384) || (diff_v > 16'd49152);
        end else begin
          out_nxt.same_direction = 1'b1;
        end
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      thresh_r     <= 32'd327680;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      thresh_r     <= thresh_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    req_r     <= req_nxt;
    cur_r     <= cur_nxt;
    stepped_r <= stepped_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    prod_r    <= prod_nxt;
    psum_r    <= psum_nxt;
    term_r    <= term_nxt;
    total_r   <= total_nxt;
    re_r      <= re_nxt;
    im_r      <= im_nxt;
    acc_r     <= acc_nxt;
    rot_i_r   <= rot_i_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rhe_pkg::*;

  localparam int MAX_PTS   = 1024;
  localparam int CORDIC_N  = 16;
  localparam int ITEMS     = 1350;
  localparam int DIRECTED  = 26;
  localparam int CALM_TAIL = 200;

  // Operation code that the block must refuse
  localparam logic [1:0] OP_BAD = 2'd3;

  localparam logic [30:0] COORD_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] THRESH_RESET = 32'd327680;

  // 0.011 and 0.01863 metres per tile unit, Q0.32
  localparam logic [63:0] XCOEF_Q32 = 64'd47244640;
  localparam logic [63:0] YCOEF_Q32 = 64'd80015241;
  localparam longint NORM_MAG = 64'sd1099511627776;

  // arctan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_Q32 [0:15] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861
  };

  // Predicts the answer to each transfer and checks the answers in order
  class heading_scoreboard;
    logic [31:0] thresh;
    logic [30:0] pt_x [MAX_PTS];
    logic [30:0] pt_y [MAX_PTS];
    bit          filled [MAX_PTS];
    int unsigned in_use;
    out_item_t   answer_q [$];
    int          mismatches;
    int          checked;
    int          headings;
    int          refusals;

    function new();
      thresh = THRESH_RESET;
      in_use = 0;
      foreach (filled[i]) filled[i] = 1'b0;
      mismatches = 0;
      checked = 0;
      headings = 0;
      refusals = 0;
    endfunction

    // Walk from a start point; returns the index of the last point reached.
    // blank is set when the walk reads a slot that was never written.
    function int walk_last(int first, bit fwd, output bit blank);
      int cur;
      bit go;
      logic [63:0] total, dx, dy;
      cur = first;
      total = 64'd0;
      go = 1'b1;
      blank = !filled[first];
      while (go) begin
        if (fwd) begin
          if (cur + 1 >= in_use) go = 1'b0;
          else cur++;
        end else begin
          if (cur == 0) go = 1'b0;
          else cur--;
        end
        if (go) begin
          if (!filled[cur]) blank = 1'b1;
          dx = (pt_x[cur] > pt_x[first]) ? pt_x[cur] - pt_x[first] : pt_x[first] - pt_x[cur];
          dy = (pt_y[cur] > pt_y[first]) ? pt_y[cur] - pt_y[first] : pt_y[first] - pt_y[cur];
          total = total + ((dx * XCOEF_Q32 + dy * YCOEF_Q32 + 64'd32768) >> 16);
          if (total >= thresh) go = 1'b0;
        end
      end
      return cur;
    endfunction

    // Binary angle of (re, im), 65536 per turn, by vectoring CORDIC
    function logic [15:0] cordic_angle(longint re, longint im);
      longint nr, ni, mag, aim;
      logic [31:0] acc, rounded;
      int i;
      if (re == 0 && im == 0) return 16'd0;
      acc = 32'd0;
      // half-turn pre-rotation keeps re non-negative
      if (re < 0) begin
        re = -re;
        im = -im;
        acc = 32'h8000_0000;
      end
      aim = (im < 0) ? -im : im;
      mag = (re > aim) ? re : aim;
      while (mag < NORM_MAG) begin
        re = re * 2;
        im = im * 2;
        mag = mag * 2;
      end
      for (i = 0; i < CORDIC_N; i++) begin
        if (im >= 0) begin
          nr = re + (im >>> i);
          ni = im - (re >>> i);
          acc = acc + ATAN_Q32[i];
        end else begin
          nr = re - (im >>> i);
          ni = im + (re >>> i);
          acc = acc - ATAN_Q32[i];
        end
        re = nr;
        im = ni;
      end
      rounded = acc + 32'h0000_8000;
      return rounded[31:16];
    endfunction

    function bit query_reads_blank(int first, bit fwd);
      bit blank;
      int unused;
      unused = walk_last(first, fwd, blank);
      return blank;
    endfunction

    // Accepted transfer: update the point store and queue the answer
    function void note_transfer(in_item_t it);
      out_item_t ans;
      int idx, last;
      bit blank;
      longint vr, vi, tmp;
      logic [15:0] ang, diff;
      ans = '0;
      idx = it.point_index;
      case (it.operation)
        OP_WRITE: begin
          if (idx < MAX_PTS) begin
            pt_x[idx] = it.coord_x;
            pt_y[idx] = it.coord_y;
            filled[idx] = 1'b1;
          end else begin
            ans.status = 1'b1;
          end
        end
        OP_COUNT: begin
          if (idx <= MAX_PTS) in_use = idx;
          else ans.status = 1'b1;
        end
        OP_QUERY: begin
          if (idx >= in_use || idx >= MAX_PTS) begin
            ans.status = 1'b1;
          end else begin
            last = walk_last(idx, it.walk_forward, blank);
            vr = pt_y[idx];
            tmp = pt_y[last];
            vr = vr - tmp;
            vi = pt_x[idx];
            tmp = pt_x[last];
            vi = vi - tmp;
            ang = 16'd0 - cordic_angle(vr, vi);
            ans.route_angle = ang;
            if (it.bearing_given) begin
              diff = ang - it.bearing_angle;
              ans.same_direction = (diff < 16'd16384) || (diff > 16'd49152);
            end else begin
              ans.same_direction = 1'b1;
            end
            headings++;
          end
        end
        default: ans.status = 1'b1;
      endcase
      if (ans.status) refusals++;
      answer_q.push_back(ans);
    endfunction

    function void check_answer(out_item_t got);
      out_item_t want;
      bit bad;
      string what;
      checked++;
      if (answer_q.size() == 0) begin
        bad = 1'b1;
        want = '0;
        what = "answer with no transfer pending";
      end else begin
        want = answer_q.pop_front();
        bad = (got.status !== want.status) ||
              (got.route_angle !== want.route_angle) ||
              (got.same_direction !== want.same_direction);
        what = "answer mismatch";
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t %s: expected status %0d angle %0d same %0d, got status %0d angle %0d same %0d",
                   $realtime, what, want.status, want.route_angle, want.same_direction,
                   got.status, got.route_angle, got.same_direction);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_result;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  heading_scoreboard board = new();
  int  sent;
  int  cfg_n;
  bit  idle_ok;

  route_heading_estimator_unit #(
    .MAX_POINTS   (MAX_PTS),
    .CORDIC_STEPS (CORDIC_N)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_result  (out_result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input transfers and answers, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_transfer(in_item);
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_answer(out_result);
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation     = 2'($urandom_range(0, 3));
    it.point_index   = 11'($urandom);
    it.coord_x       = 31'($urandom);
    it.coord_y       = 31'($urandom);
    it.walk_forward  = 1'($urandom);
    it.bearing_angle = 16'($urandom);
    it.bearing_given = 1'($urandom);
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(in_item_t it);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_write(int idx, logic [30:0] x, logic [30:0] y);
    in_item_t it;
    it = random_item();
    it.operation = OP_WRITE;
    it.point_index = 11'(idx);
    it.coord_x = x;
    it.coord_y = y;
    send_item(it);
  endtask

  task automatic send_count(int n);
    in_item_t it;
    it = random_item();
    it.operation = OP_COUNT;
    it.point_index = 11'(n);
    send_item(it);
  endtask

  // A query whose walk would read a never-written slot becomes a
  // start-out-of-range query instead
  task automatic send_query(int idx, bit fwd, logic [15:0] bearing, bit given);
    in_item_t it;
    it = random_item();
    it.operation = OP_QUERY;
    it.point_index = 11'(idx);
    it.walk_forward = fwd;
    it.bearing_angle = bearing;
    it.bearing_given = given;
    if (idx < board.in_use && board.query_reads_blank(idx, fwd))
      it.point_index = 11'(board.in_use + $urandom_range(0, 2047 - board.in_use));
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it = random_item();
    case ($urandom_range(0, 3))
      0: begin
        it.operation = OP_WRITE;
        it.point_index = 11'($urandom_range(MAX_PTS, 2047));
        send_item(it);
      end
      1: begin
        it.operation = OP_BAD;
        send_item(it);
      end
      2: begin
        it.operation = OP_COUNT;
        it.point_index = 11'($urandom_range(MAX_PTS + 1, 2047));
        send_item(it);
      end
      default: send_query($urandom_range(0, 2047), 1'($urandom), 16'($urandom), 1'($urandom));
    endcase
  endtask

  // Threshold is only written once every answer is back
  task automatic load_threshold(logic [31:0] value);
    start = 1'b0;
    while (board.answer_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    board.thresh = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_n++;
  endtask

  task automatic directed_items();
    // no points in use yet
    send_query(0, 1'b1, 16'h0000, 1'b1);
    send_write(MAX_PTS, COORD_MAX, COORD_MAX);
    send_write(2047, 31'd0, 31'd0);
    send_item(random_item() | {OP_BAD, 91'd0});
    send_count(MAX_PTS + 1);
    // corner coordinates, with a duplicate pair at the end
    send_write(0, 31'd0, 31'd0);
    send_write(1, 31'd0, COORD_MAX);
    send_write(2, COORD_MAX, COORD_MAX);
    send_write(3, COORD_MAX, 31'd0);
    send_write(4, COORD_MAX, 31'd0);
    send_count(5);
    // due south gives the wrapped half turn
    send_query(0, 1'b1, 16'h8000, 1'b1);
    // zero vector after a zero-length step, bearing at the lower edge
    send_query(3, 1'b1, 16'h4000, 1'b1);
    // no step possible, bearing at the upper edge
    send_query(4, 1'b1, 16'hC000, 1'b1);
    send_query(0, 1'b0, 16'h1234, 1'b0);
    send_query(2, 1'b0, 16'hFFFF, 1'b1);
    send_query(4, 1'b0, 16'h0000, 1'b1);
    send_query(5, 1'b1, 16'h0000, 1'b1);
    load_threshold(32'd0);
    send_query(4, 1'b0, 16'($urandom), 1'b1);
    send_query(1, 1'b1, 16'($urandom), 1'b1);
    // top of the store
    send_write(MAX_PTS - 2, 31'd5, COORD_MAX);
    send_write(MAX_PTS - 1, COORD_MAX, COORD_MAX);
    send_count(MAX_PTS);
    send_query(MAX_PTS - 1, 1'b1, 16'($urandom), 1'b1);
    send_query(MAX_PTS - 1, 1'b0, 16'($urandom), 1'b1);
    send_count(0);
  endtask

  // One road: a polyline of points, the count, then queries along it
  task automatic road_episode();
    int base, k, nq, i, idx;
    longint x, y, d, stride;
    int unsigned span;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(2, 24);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: base = 0;
      6, 7:             base = $urandom_range(0, MAX_PTS - k);
      default:          base = MAX_PTS - k;
    endcase
    case ($urandom_range(0, 4))
      0:       stride = 3;
      1:       stride = 400;
      2:       stride = 5000;
      3:       stride = 1 << 20;
      default: stride = COORD_MAX;
    endcase
    span = 32'(2 * stride);
    x = 31'($urandom);
    y = 31'($urandom);
    if ($urandom_range(0, 4) == 0) x = $urandom_range(0, 1) ? COORD_MAX : 0;
    if ($urandom_range(0, 4) == 0) y = $urandom_range(0, 1) ? COORD_MAX : 0;
    for (i = 0; i < k; i++) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_write(base + i, 31'(x), 31'(y));
      d = $urandom_range(0, span);
      x = x + d - stride;
      d = $urandom_range(0, span);
      y = y + d - stride;
      if (x < 0) x = 0;
      if (x > COORD_MAX) x = COORD_MAX;
      if (y < 0) y = 0;
      if (y > COORD_MAX) y = COORD_MAX;
    end
    if ($urandom_range(0, 5) == 0) send_count($urandom_range(0, base + k));
    else send_count(base + k);
    nq = $urandom_range(2, 12);
    for (i = 0; i < nq; i++) begin
      if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 2047);
      else idx = base + $urandom_range(0, k - 1);
      if ($urandom_range(0, 15) == 0) send_noise();
      send_query(idx, 1'($urandom), 16'($urandom), $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic pick_threshold();
    case (cfg_n % 5)
      0:       load_threshold(32'hFFFF_FFFF);
      1:       load_threshold(THRESH_RESET);
      2:       load_threshold(32'($urandom_range(1, 1 << 24)));
      3:       load_threshold(32'd0);
      default: load_threshold($urandom);
    endcase
  endtask

  // Stimulus and end of run
  initial begin
    int roads;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'd0;
    sent = 0;
    cfg_n = 0;
    roads = 0;
    idle_ok = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_items();
    while (sent < DIRECTED + ITEMS) begin
      if (roads % 3 == 0) pick_threshold();
      idle_ok = (sent < DIRECTED + ITEMS - CALM_TAIL) && ($urandom_range(0, 9) >= 3);
      road_episode();
      roads++;
    end

    start = 1'b0;
    while (board.answer_q.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (board.answer_q.size() != 0) board.mismatches++;

    $display("Covered %0d transfers on %0d roads under %0d threshold settings", sent, roads, cfg_n);
    $display("Checked %0d answers: %0d headings, %0d refusals", board.checked, board.headings,
             board.refusals);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
